### rtl/cggr_pkg.sv
// cggr_pkg: shared constants, control struct and elaboration-time helpers
// for the gain and gamma ramp pipeline. No dependencies.
package cggr_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int GAMMA_FRAC_BITS = 12;
  localparam int LOG_FRAC        = 28;

  localparam int GAIN_W  = 17;
  localparam int GAMMA_W = 16;
  localparam int CH_W    = 2;
  localparam int DATA_W  = 16;

  localparam int P_W = SAMPLE_BITS + GAIN_W;
  localparam int E_W = $clog2(P_W);
  localparam int A_W = E_W + LOG_FRAC;
  localparam int M_W = 31;
  localparam int T_W = A_W + GAMMA_W + 1;
  localparam int N_W = T_W - GAMMA_FRAC_BITS - LOG_FRAC;
  localparam int SH_W = 5;
  localparam int R_W = SAMPLE_BITS + 1;

  localparam logic [SAMPLE_BITS-1:0] FS = {SAMPLE_BITS{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);
  localparam logic [GAMMA_W-1:0] GAMMA_ONE = GAMMA_W'(1 << GAMMA_FRAC_BITS);
  localparam logic [M_W-1:0] Q30_ONE = M_W'(1 << 30);
  localparam logic [N_W-1:0] N_LIMIT = N_W'(17);

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic [1:0] REG_RED   = 2'd0;
  localparam logic [1:0] REG_GREEN = 2'd1;
  localparam logic [1:0] REG_BLUE  = 2'd2;
  localparam logic [1:0] REG_GAMMA = 2'd3;

  localparam logic [1:0] KIND_CALC = 2'd0;
  localparam logic [1:0] KIND_FULL = 2'd1;
  localparam logic [1:0] KIND_ZERO = 2'd2;

  typedef struct packed {
    logic            valid;
    logic [CH_W-1:0] ch;
    logic [1:0]      kind;
  } ctl_t;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] vv;
    r  = '0;
    vv = v;
    for (int i = 31; i >= 0; i--) begin
      b = 64'd1 << (2 * i);
      if (vv >= r + b) begin
        vv = vv - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] log2_q28(input logic [63:0] v);
    int          e;
    logic [63:0] m;
    logic [63:0] frac;
    e    = 0;
    frac = '0;
    for (int j = 0; j < 63; j++) begin
      if ((v >> (j + 1)) != 0) e = j + 1;
    end
    if (e >= 30) m = v >> (e - 30);
    else m = v << (30 - e);
    for (int i = LOG_FRAC - 1; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | (64'd1 << i);
      end
    end
    return (64'(e) << LOG_FRAC) | frac;
  endfunction

  function automatic logic [M_W-1:0] exp_c(input int k);
    logic [63:0] c;
    c = int_sqrt(64'd1 << 59);
    for (int j = 0; j < k; j++) begin
      c = int_sqrt(c << 30);
    end
    return M_W'(c);
  endfunction

  localparam logic [A_W-1:0] LREF =
    A_W'(log2_q28(64'(FS)) + (64'd16 << LOG_FRAC));

endpackage

### rtl/channel_gain_gamma_ramp_top.sv
// channel_gain_gamma_ramp_top: per-channel gain, clamp and fixed-point gamma
// on 16-bit ramp entries. Depends on cggr_pkg.
// The log2 squaring chain has 28 stages and the exp2 product chain has 28 stages;
// throughput one item per cycle while no result waits on the output.
// The whole pipeline halts while a result waits on the output.
// Reset (rst, synchronous): clears all valid bits, gains to 1.0, gamma to 1.0.
module channel_gain_gamma_ramp_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [16:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // sample_in[15:0]
  input  logic [1:0]  s_tuser,   // channel_sel[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // ramp_out[15:0]
  output logic [1:0]  m_tuser    // channel_out[1:0]
);

  localparam int LF = cggr_pkg::LOG_FRAC;
  localparam int MW = cggr_pkg::M_W;
  localparam int SB = cggr_pkg::SAMPLE_BITS;
  localparam int GF = cggr_pkg::GAMMA_FRAC_BITS;

  logic [cggr_pkg::GAIN_W-1:0]  red_gain;
  logic [cggr_pkg::GAIN_W-1:0]  green_gain;
  logic [cggr_pkg::GAIN_W-1:0]  blue_gain;
  logic [cggr_pkg::GAMMA_W-1:0] gamma_exponent;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_gain       <= cggr_pkg::GAIN_ONE;
      green_gain     <= cggr_pkg::GAIN_ONE;
      blue_gain      <= cggr_pkg::GAIN_ONE;
      gamma_exponent <= cggr_pkg::GAMMA_ONE;
    end else if (cfg_we) begin
      case (cfg_addr)
        cggr_pkg::REG_RED:   red_gain <= cfg_wdata;
        cggr_pkg::REG_GREEN: green_gain <= cfg_wdata;
        cggr_pkg::REG_BLUE:  blue_gain <= cfg_wdata;
        cggr_pkg::REG_GAMMA: gamma_exponent <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // stage 1: gain select and product
  logic [cggr_pkg::GAIN_W-1:0] gain_sel;
  always_comb begin
    case (s_tuser)
      cggr_pkg::CH_RED:   gain_sel = red_gain;
      cggr_pkg::CH_GREEN: gain_sel = green_gain;
      cggr_pkg::CH_BLUE:  gain_sel = blue_gain;
      default:            gain_sel = cggr_pkg::GAIN_ONE;
    endcase
  end

  cggr_pkg::ctl_t           ctl1;
  logic [cggr_pkg::P_W-1:0] p1;
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else if (ce) begin
      ctl1.valid <= s_tvalid;
      ctl1.ch    <= s_tuser;
      ctl1.kind  <= cggr_pkg::KIND_CALC;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) p1 <= cggr_pkg::P_W'(s_tdata[SB-1:0]) * cggr_pkg::P_W'(gain_sel);
  end

  // stage 2: leading one and special cases
  logic [cggr_pkg::E_W-1:0] e_c;
  always_comb begin
    e_c = '0;
    for (int j = 0; j < cggr_pkg::P_W; j++) begin
      if (p1[j]) e_c = cggr_pkg::E_W'(j);
    end
  end

  cggr_pkg::ctl_t           ctl2;
  logic [cggr_pkg::P_W-1:0] p2;
  logic [cggr_pkg::E_W-1:0] e2;
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2 <= '0;
    end else if (ce) begin
      ctl2.valid <= ctl1.valid;
      ctl2.ch    <= ctl1.ch;
      if (gamma_exponent == '0 || p1 >= (cggr_pkg::P_W'(cggr_pkg::FS) << 16)) begin
        ctl2.kind <= cggr_pkg::KIND_FULL;
      end else if (p1 == '0) begin
        ctl2.kind <= cggr_pkg::KIND_ZERO;
      end else begin
        ctl2.kind <= cggr_pkg::KIND_CALC;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      p2 <= p1;
      e2 <= e_c;
    end
  end

  // stage 3: normalize to q30 mantissa, then log2 squaring chain
  logic [cggr_pkg::P_W+30-1:0] norm_w;
  assign norm_w = {p2, 30'd0} >> e2;

  cggr_pkg::ctl_t           lg_ctl  [0:LF];
  logic [MW-1:0]            lg_m    [0:LF];
  logic [LF-1:0]            lg_frac [0:LF];
  logic [cggr_pkg::E_W-1:0] lg_e    [0:LF];

  always_ff @(posedge clk) begin
    if (rst) begin
      lg_ctl[0] <= '0;
    end else if (ce) begin
      lg_ctl[0] <= ctl2;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      lg_m[0]    <= norm_w[MW-1:0];
      lg_frac[0] <= '0;
      lg_e[0]    <= e2;
    end
  end

  for (genvar k = 0; k < LF; k++) begin : g_log
    logic [2*MW-1:0] sq;
    logic [MW:0]     q;
    assign sq = lg_m[k] * lg_m[k];
    assign q  = sq[2*MW-1:30];
    always_ff @(posedge clk) begin
      if (rst) begin
        lg_ctl[k+1] <= '0;
      end else if (ce) begin
        lg_ctl[k+1] <= lg_ctl[k];
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        lg_m[k+1]    <= q[MW] ? q[MW:1] : q[MW-1:0];
        lg_frac[k+1] <= {lg_frac[k][LF-2:0], q[MW]};
        lg_e[k+1]    <= lg_e[k];
      end
    end
  end

  // magnitude below full scale
  logic [cggr_pkg::A_W-1:0] lp;
  assign lp = {lg_e[LF], lg_frac[LF]};

  cggr_pkg::ctl_t           ctl_a;
  logic [cggr_pkg::A_W-1:0] mag_a;
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
    end else if (ce) begin
      ctl_a <= lg_ctl[LF];
    end
  end
  always_ff @(posedge clk) begin
    if (ce) mag_a <= (lp >= cggr_pkg::LREF) ? '0 : cggr_pkg::LREF - lp;
  end

  // scale by gamma with round half up
  logic [cggr_pkg::T_W-1:0] tsum;
  logic [cggr_pkg::N_W-1:0] n_c;
  assign tsum = cggr_pkg::T_W'(mag_a) * cggr_pkg::T_W'(gamma_exponent)
              + cggr_pkg::T_W'(1 << (GF - 1));
  assign n_c  = tsum[cggr_pkg::T_W-1:GF+LF];

  cggr_pkg::ctl_t ctl_t1;
  logic [LF-1:0]  f_t;
  logic [cggr_pkg::SH_W-1:0] n_t;
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_t1 <= '0;
    end else if (ce) begin
      ctl_t1.valid <= ctl_a.valid;
      ctl_t1.ch    <= ctl_a.ch;
      if (ctl_a.kind == cggr_pkg::KIND_CALC && n_c >= cggr_pkg::N_LIMIT) begin
        ctl_t1.kind <= cggr_pkg::KIND_ZERO;
      end else begin
        ctl_t1.kind <= ctl_a.kind;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      f_t <= tsum[GF+LF-1:GF];
      n_t <= n_c[cggr_pkg::SH_W-1:0];
    end
  end

  // exp2 of the fraction: one constant factor per bit
  cggr_pkg::ctl_t           ex_ctl [0:LF];
  logic [MW-1:0]            ex_m   [0:LF];
  logic [LF-1:0]            ex_f   [0:LF];
  logic [cggr_pkg::SH_W-1:0] ex_n  [0:LF];

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_ctl[0] <= '0;
    end else if (ce) begin
      ex_ctl[0] <= ctl_t1;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      ex_m[0] <= cggr_pkg::Q30_ONE;
      ex_f[0] <= f_t;
      ex_n[0] <= n_t;
    end
  end

  for (genvar k = 0; k < LF; k++) begin : g_exp
    localparam logic [MW-1:0] CK = cggr_pkg::exp_c(k);
    logic [2*MW-1:0] prod;
    assign prod = ex_m[k] * CK + (2*MW)'(1 << 29);
    always_ff @(posedge clk) begin
      if (rst) begin
        ex_ctl[k+1] <= '0;
      end else if (ce) begin
        ex_ctl[k+1] <= ex_ctl[k];
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        ex_m[k+1] <= ex_f[k][LF-1] ? prod[MW+29:30] : ex_m[k];
        ex_f[k+1] <= {ex_f[k][LF-2:0], 1'b0};
        ex_n[k+1] <= ex_n[k];
      end
    end
  end

  // integer part shift
  cggr_pkg::ctl_t ctl_s;
  logic [MW-1:0]  m_s;
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s <= '0;
    end else if (ce) begin
      ctl_s <= ex_ctl[LF];
    end
  end
  always_ff @(posedge clk) begin
    if (ce) m_s <= ex_m[LF] >> ex_n[LF];
  end

  // scale to full scale
  logic [MW+SB-1:0] fs_prod;
  assign fs_prod = (MW+SB)'(m_s) * (MW+SB)'(cggr_pkg::FS);

  cggr_pkg::ctl_t           ctl_r;
  logic [cggr_pkg::R_W-1:0] res_r;
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_r <= '0;
    end else if (ce) begin
      ctl_r <= ctl_s;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) res_r <= fs_prod[MW+SB-1:30];
  end

  // output register with clamp and special cases
  logic [SB-1:0] res_fin;
  always_comb begin
    case (ctl_r.kind)
      cggr_pkg::KIND_FULL: res_fin = cggr_pkg::FS;
      cggr_pkg::KIND_ZERO: res_fin = '0;
      default: res_fin = (res_r > cggr_pkg::R_W'(cggr_pkg::FS)) ? cggr_pkg::FS
                                                                : res_r[SB-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= ctl_r.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= 16'(res_fin);
      m_tuser <= ctl_r.ch;
    end
  end

  a_reset_clears : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hold_result : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_norm : assert property (@(posedge clk) disable iff (rst)
    lg_ctl[0].valid && lg_ctl[0].kind == cggr_pkg::KIND_CALC |-> lg_m[0][30])
    else $error("log mantissa not normalized");

  a_exp_range : assert property (@(posedge clk) disable iff (rst)
    ex_ctl[LF].valid |-> ex_m[LF] <= cggr_pkg::Q30_ONE)
    else $error("exp product above one");

endmodule
